// ----- rtl/core/rms_pkg.sv -----
`default_nettype none

package rms_pkg;

    // storage sizes
    localparam int MEM_WORDS = 256;
    localparam int REG_COUNT = 16;
    localparam int MEM_AW    = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int RF_AW     = $clog2(REG_COUNT);

    // register numbers and address limits
    localparam logic [RF_AW-1:0] PC_REG     = RF_AW'(REG_COUNT - 1);
    localparam logic [31:0]      ADDR_LIMIT = 32'd1023;

    // request kinds
    localparam logic [1:0] REQ_MEM_WR = 2'd0;
    localparam logic [1:0] REQ_REG_WR = 2'd1;
    localparam logic [1:0] REQ_EXEC   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BAD_OP = 2'd1;
    localparam logic [1:0] ST_BOUNDS = 2'd2;
    localparam logic [1:0] ST_UNIMPL = 2'd3;

    // opcodes
    localparam logic [7:0] OP_LDR = 8'd1;
    localparam logic [7:0] OP_LDI = 8'd2;
    localparam logic [7:0] OP_LDX = 8'd3;
    localparam logic [7:0] OP_ADD = 8'd5;
    localparam logic [7:0] OP_SUB = 8'd6;
    localparam logic [7:0] OP_CMP = 8'd9;
    localparam logic [7:0] OP_B   = 8'd10;
    localparam logic [7:0] OP_BEQ = 8'd11;
    localparam logic [7:0] OP_BNE = 8'd12;
    localparam logic [7:0] OP_BLT = 8'd13;
    localparam logic [7:0] OP_BGT = 8'd14;

    // shared adder request and result
    typedef struct packed {
        logic        sub;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] sum;
        logic        eq;
        logic        lt;
    } alu_res_t;

    // register file write port
    typedef struct packed {
        logic             we;
        logic [RF_AW-1:0] addr;
        logic [31:0]      data;
    } rf_wr_t;

    // word memory port
    typedef struct packed {
        logic              we;
        logic              re;
        logic [MEM_AW-1:0] addr;
        logic [31:0]       wdata;
    } mem_req_t;

    // byte address falls inside the word memory
    function automatic logic in_memory(input logic [31:0] byte_addr);
        return {2'b00, byte_addr[31:2]} < 32'(MEM_WORDS);
    endfunction

    // word index of a byte address
    function automatic logic [MEM_AW-1:0] word_index(input logic [31:0] byte_addr);
        return byte_addr[MEM_AW+1:2];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/register_machine_step.sv -----
`default_nettype none

// Small 16-register processor step engine with R15 as program counter and an
// internal word memory. Each accepted request yields exactly one result word.
// Memory writes, register writes and the unused request kind go straight to
// S_DONE; an execute request passes S_DECODE and S_EXEC (fetch through the
// single-port word memory, registered register file read, one pass of the
// shared adder), LDR and LDX also S_LOAD, as they read the word memory a
// second time, or goes to S_DONE at once when PC lies outside the memory.
// The one adder serves PC + 4, ADD, SUB, CMP, the LDX address and the B
// target in turn. req_ready is high only between requests; a new request may
// be taken while the previous result still waits in the output register, and
// it then holds in its final step until that result is taken. The word memory
// has no reset: a word that was never written must not be read.
module register_machine_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  req_type,
    input  logic [9:0]  mem_address,
    input  logic [3:0]  reg_index,
    input  logic [31:0] data,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  status,
    output logic [31:0] program_counter,
    output logic [31:0] fetched_word,
    output logic        reg_written,
    output logic [3:0]  written_reg,
    output logic [31:0] written_value,
    output logic        branch_taken,
    output logic        flag_equal,
    output logic        flag_less,
    output logic        flag_greater
);
    import rms_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_LOAD,
        S_DONE
    } state_t;

    state_t      state_reg, state_next;
    logic [31:0] pc_reg, pc_next;
    logic [2:0]  flags_reg, flags_next;
    logic [31:0] next_pc_reg, next_pc_next;
    logic [31:0] inst_reg, inst_next;

    // result under construction
    logic [1:0]  cur_status_reg, cur_status_next;
    logic [31:0] cur_fetched_reg, cur_fetched_next;
    logic        cur_wrote_reg, cur_wrote_next;
    logic [3:0]  cur_wreg_reg, cur_wreg_next;
    logic [31:0] cur_wval_reg, cur_wval_next;
    logic        cur_taken_reg, cur_taken_next;

    // output register
    logic        res_valid_reg, res_valid_next;
    logic [1:0]  res_status_reg, res_status_next;
    logic [31:0] res_pc_reg, res_pc_next;
    logic [31:0] res_fetched_reg, res_fetched_next;
    logic        res_wrote_reg, res_wrote_next;
    logic [3:0]  res_wreg_reg, res_wreg_next;
    logic [31:0] res_wval_reg, res_wval_next;
    logic        res_taken_reg, res_taken_next;
    logic [2:0]  res_flags_reg, res_flags_next;

    alu_req_t    alu_req;
    alu_res_t    alu_res;
    rf_wr_t      rf_wr;
    logic [3:0]  rf_raddr0;
    logic [3:0]  rf_raddr1;
    logic [31:0] rf_rdata0;
    logic [31:0] rf_rdata1;
    mem_req_t    mem_req;
    logic [31:0] mem_rdata;

    logic        dest_en;
    logic [31:0] dest_val;
    logic        cond;
    logic        accept;

    // instruction fields
    logic [7:0]  op;
    logic [7:0]  fa;
    logic [7:0]  fb;
    logic [7:0]  fc;
    logic [23:0] tgt;
    logic [31:0] val_b;
    logic [31:0] val_c;
    logic        fa_ok;
    logic        fb_ok;
    logic        fc_ok;
    logic        tgt_ok;

    rms_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    rms_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (rf_wr),
        .raddr0 (rf_raddr0),
        .raddr1 (rf_raddr1),
        .rdata0 (rf_rdata0),
        .rdata1 (rf_rdata1)
    );

    rms_wordmem u_wordmem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;

    assign op     = inst_reg[31:24];
    assign fa     = inst_reg[23:16];
    assign fb     = inst_reg[15:8];
    assign fc     = inst_reg[7:0];
    assign tgt    = inst_reg[23:0];
    assign fa_ok  = (fa[7:4] == 4'd0);
    assign fb_ok  = (fb[7:4] == 4'd0);
    assign fc_ok  = (fc[7:4] == 4'd0);
    assign tgt_ok = ({8'd0, tgt} <= ADDR_LIMIT);

    // R15 reads come from the program counter
    assign val_b = (fb[3:0] == PC_REG) ? pc_reg : rf_rdata0;
    assign val_c = (fc[3:0] == PC_REG) ? pc_reg : rf_rdata1;

    // branch condition from the stored flags
    always_comb
    begin
        case (op)
            OP_BEQ:  cond = flags_reg[0];
            OP_BNE:  cond = !flags_reg[0];
            OP_BLT:  cond = flags_reg[1];
            OP_BGT:  cond = flags_reg[2];
            default: cond = 1'b0;
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        pc_next          = pc_reg;
        flags_next       = flags_reg;
        next_pc_next     = next_pc_reg;
        inst_next        = inst_reg;
        cur_status_next  = cur_status_reg;
        cur_fetched_next = cur_fetched_reg;
        cur_wrote_next   = cur_wrote_reg;
        cur_wreg_next    = cur_wreg_reg;
        cur_wval_next    = cur_wval_reg;
        cur_taken_next   = cur_taken_reg;
        res_valid_next   = res_valid_reg;
        res_status_next  = res_status_reg;
        res_pc_next      = res_pc_reg;
        res_fetched_next = res_fetched_reg;
        res_wrote_next   = res_wrote_reg;
        res_wreg_next    = res_wreg_reg;
        res_wval_next    = res_wval_reg;
        res_taken_next   = res_taken_reg;
        res_flags_next   = res_flags_reg;

        alu_req   = '{sub: 1'b0, a: pc_reg, b: 32'd4};
        rf_wr     = '{we: 1'b0, addr: reg_index, data: data};
        rf_raddr0 = mem_rdata[11:8];
        rf_raddr1 = mem_rdata[3:0];
        mem_req   = '{we: 1'b0, re: 1'b0, addr: word_index({22'd0, mem_address}),
                      wdata: data};
        dest_en   = 1'b0;
        dest_val  = mem_rdata;

        // output word leaves
        if (res_valid_reg && res_ready)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cur_status_next  = ST_OK;
                    cur_fetched_next = 32'd0;
                    cur_wrote_next   = 1'b0;
                    cur_wreg_next    = 4'd0;
                    cur_wval_next    = 32'd0;
                    cur_taken_next   = 1'b0;
                    state_next       = S_DONE;
                    case (req_type)
                        REQ_MEM_WR:
                        begin
                            if (in_memory({22'd0, mem_address}))
                            begin
                                mem_req.we = 1'b1;
                            end
                            else
                            begin
                                cur_status_next = ST_BOUNDS;
                            end
                        end
                        REQ_REG_WR:
                        begin
                            if (reg_index == PC_REG)
                            begin
                                pc_next = data;
                            end
                            else
                            begin
                                rf_wr.we       = 1'b1;
                                cur_wrote_next = 1'b1;
                                cur_wreg_next  = reg_index;
                                cur_wval_next  = data;
                            end
                        end
                        REQ_EXEC:
                        begin
                            if (in_memory(pc_reg))
                            begin
                                mem_req.re   = 1'b1;
                                mem_req.addr = word_index(pc_reg);
                                state_next   = S_DECODE;
                            end
                            else
                            begin
                                cur_status_next = ST_BOUNDS;
                            end
                        end
                        default:
                        begin
                            cur_status_next = ST_OK;
                        end
                    endcase
                end
            end

            // instruction word arrives, read operands, form PC + 4
            S_DECODE:
            begin
                inst_next    = mem_rdata;
                next_pc_next = alu_res.sum;
                state_next   = S_EXEC;
            end

            S_EXEC:
            begin
                cur_fetched_next = inst_reg;
                state_next       = S_DONE;
                if (op[7:4] != 4'd0)
                begin
                    cur_status_next = ST_BAD_OP;
                end
                else
                begin
                    case (op)
                        OP_LDR:
                        begin
                            if (!fa_ok || ({16'd0, inst_reg[15:0]} > ADDR_LIMIT)
                                || !in_memory({16'd0, inst_reg[15:0]}))
                            begin
                                cur_status_next = ST_BOUNDS;
                            end
                            else
                            begin
                                mem_req.re   = 1'b1;
                                mem_req.addr = word_index({16'd0, inst_reg[15:0]});
                                state_next   = S_LOAD;
                            end
                        end
                        OP_LDI:
                        begin
                            if (!fa_ok)
                            begin
                                cur_status_next = ST_BOUNDS;
                            end
                            else
                            begin
                                dest_en  = 1'b1;
                                dest_val = {16'd0, inst_reg[15:0]};
                            end
                        end
                        OP_LDX:
                        begin
                            alu_req = '{sub: 1'b0, a: val_c, b: {24'd0, fb}};
                            if (!fa_ok || !fc_ok || (alu_res.sum > ADDR_LIMIT)
                                || !in_memory(alu_res.sum))
                            begin
                                cur_status_next = ST_BOUNDS;
                            end
                            else
                            begin
                                mem_req.re   = 1'b1;
                                mem_req.addr = word_index(alu_res.sum);
                                state_next   = S_LOAD;
                            end
                        end
                        OP_ADD, OP_SUB:
                        begin
                            alu_req = '{sub: (op == OP_SUB), a: val_b, b: val_c};
                            if (!fa_ok || !fb_ok || !fc_ok)
                            begin
                                cur_status_next = ST_BOUNDS;
                            end
                            else
                            begin
                                dest_en  = 1'b1;
                                dest_val = alu_res.sum;
                            end
                        end
                        OP_CMP:
                        begin
                            alu_req = '{sub: 1'b1, a: val_b, b: val_c};
                            if (!fb_ok || !fc_ok)
                            begin
                                cur_status_next = ST_BOUNDS;
                            end
                            else
                            begin
                                flags_next = alu_res.eq ? 3'b001 :
                                             alu_res.lt ? 3'b010 : 3'b100;
                                pc_next    = next_pc_reg;
                            end
                        end
                        OP_B:
                        begin
                            alu_req = '{sub: 1'b0, a: {8'd0, tgt}, b: 32'd4};
                            if (!tgt_ok)
                            begin
                                cur_status_next = ST_BOUNDS;
                            end
                            else
                            begin
                                pc_next        = alu_res.sum;
                                cur_taken_next = 1'b1;
                            end
                        end
                        OP_BEQ, OP_BNE, OP_BLT, OP_BGT:
                        begin
                            if (!tgt_ok)
                            begin
                                cur_status_next = ST_BOUNDS;
                            end
                            else if (cond)
                            begin
                                pc_next        = {8'd0, tgt};
                                cur_taken_next = 1'b1;
                            end
                            else
                            begin
                                pc_next = next_pc_reg;
                            end
                        end
                        default:
                        begin
                            cur_status_next = ST_UNIMPL;
                        end
                    endcase
                end
            end

            // loaded word arrives
            S_LOAD:
            begin
                dest_en    = 1'b1;
                dest_val   = mem_rdata;
                state_next = S_DONE;
            end

            // move the result into the output register once it is free
            S_DONE:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_valid_next   = 1'b1;
                    res_status_next  = cur_status_reg;
                    res_pc_next      = pc_reg;
                    res_fetched_next = cur_fetched_reg;
                    res_wrote_next   = cur_wrote_reg;
                    res_wreg_next    = cur_wreg_reg;
                    res_wval_next    = cur_wval_reg;
                    res_taken_next   = cur_taken_reg;
                    res_flags_next   = flags_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // destination write back; R15 as destination only advances the PC
        if (dest_en)
        begin
            pc_next = next_pc_reg;
            if (fa[3:0] != PC_REG)
            begin
                rf_wr          = '{we: 1'b1, addr: fa[3:0], data: dest_val};
                cur_wrote_next = 1'b1;
                cur_wreg_next  = fa[3:0];
                cur_wval_next  = dest_val;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pc_reg          <= 32'd0;
            flags_reg       <= 3'd0;
            next_pc_reg     <= 32'd0;
            inst_reg        <= 32'd0;
            cur_status_reg  <= ST_OK;
            cur_fetched_reg <= 32'd0;
            cur_wrote_reg   <= 1'b0;
            cur_wreg_reg    <= 4'd0;
            cur_wval_reg    <= 32'd0;
            cur_taken_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
            res_status_reg  <= ST_OK;
            res_pc_reg      <= 32'd0;
            res_fetched_reg <= 32'd0;
            res_wrote_reg   <= 1'b0;
            res_wreg_reg    <= 4'd0;
            res_wval_reg    <= 32'd0;
            res_taken_reg   <= 1'b0;
            res_flags_reg   <= 3'd0;
        end
        else
        begin
            state_reg       <= state_next;
            pc_reg          <= pc_next;
            flags_reg       <= flags_next;
            next_pc_reg     <= next_pc_next;
            inst_reg        <= inst_next;
            cur_status_reg  <= cur_status_next;
            cur_fetched_reg <= cur_fetched_next;
            cur_wrote_reg   <= cur_wrote_next;
            cur_wreg_reg    <= cur_wreg_next;
            cur_wval_reg    <= cur_wval_next;
            cur_taken_reg   <= cur_taken_next;
            res_valid_reg   <= res_valid_next;
            res_status_reg  <= res_status_next;
            res_pc_reg      <= res_pc_next;
            res_fetched_reg <= res_fetched_next;
            res_wrote_reg   <= res_wrote_next;
            res_wreg_reg    <= res_wreg_next;
            res_wval_reg    <= res_wval_next;
            res_taken_reg   <= res_taken_next;
            res_flags_reg   <= res_flags_next;
        end
    end

    assign res_valid       = res_valid_reg;
    assign status          = res_status_reg;
    assign program_counter = res_pc_reg;
    assign fetched_word    = res_fetched_reg;
    assign reg_written     = res_wrote_reg;
    assign written_reg     = res_wreg_reg;
    assign written_value   = res_wval_reg;
    assign branch_taken    = res_taken_reg;
    assign flag_equal      = res_flags_reg[0];
    assign flag_less       = res_flags_reg[1];
    assign flag_greater    = res_flags_reg[2];

    // checks
    a_flags_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(flags_reg))
        else $error("compare flags hold more than one bit");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req_ready)
        else $error("ready right after accepting a word");

    a_pc_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && !req_valid) |=> $stable(pc_reg))
        else $error("pc changed while idle");

    a_no_pc_write_report: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && reg_written) |-> (written_reg != PC_REG))
        else $error("pc reported as a general register write");

    a_fault_no_effect: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (status == ST_BAD_OP || status == ST_UNIMPL || status == ST_BOUNDS))
        |-> (!reg_written && !branch_taken))
        else $error("faulting word reports a write or branch");

endmodule

`default_nettype wire

// ----- rtl/core/rms_alu.sv -----
`default_nettype none

module rms_alu (
    input  rms_pkg::alu_req_t req,
    output rms_pkg::alu_res_t res
);
    import rms_pkg::*;

    logic [32:0] a_ext;
    logic [32:0] b_ext;
    logic [32:0] total;

    // one 33-bit adder, sign extended so the subtract also gives signed less-than
    always_comb
    begin
        a_ext   = {req.a[31], req.a};
        b_ext   = req.sub ? ~{req.b[31], req.b} : {req.b[31], req.b};
        total   = a_ext + b_ext + {32'd0, req.sub};
        res.sum = total[31:0];
        res.eq  = (total[31:0] == 32'd0);
        res.lt  = total[32];
    end

endmodule

`default_nettype wire

// ----- rtl/core/rms_regfile.sv -----
`default_nettype none

module rms_regfile (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rms_pkg::rf_wr_t             wr,
    input  logic [rms_pkg::RF_AW-1:0]   raddr0,
    input  logic [rms_pkg::RF_AW-1:0]   raddr1,
    output logic [31:0]                 rdata0,
    output logic [31:0]                 rdata1
);
    import rms_pkg::*;

    logic [31:0]          regs_mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [31:0]          rdata0_reg;
    logic [31:0]          rdata1_reg;

    // entry valid bits, cleared by reset so unwritten entries read zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.we)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // storage and registered reads
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            regs_mem[wr.addr] <= wr.data;
        end
        rdata0_reg <= valid_reg[raddr0] ? regs_mem[raddr0] : 32'd0;
        rdata1_reg <= valid_reg[raddr1] ? regs_mem[raddr1] : 32'd0;
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

// ----- rtl/core/rms_wordmem.sv -----
`default_nettype none

module rms_wordmem (
    input  logic               clk,
    input  rms_pkg::mem_req_t  req,
    output logic [31:0]        rdata
);
    import rms_pkg::*;

    logic [31:0] words_mem [MEM_WORDS];
    logic [31:0] rdata_reg;

    // single port, registered read
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            words_mem[req.addr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= words_mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
